// ===== sv/lahf_pkg.sv =====
// Shared types and constants of the level averaging fill valve controller.
package lahf_pkg;

	localparam int unsigned LVL_W = 16;
	localparam int unsigned CFG_W = 7;

	localparam logic [1:0] OP_SAMPLE = 2'd0;
	localparam logic [1:0] OP_VALVE  = 2'd1;
	localparam logic [1:0] OP_AUTO   = 2'd2;

	localparam logic [1:0] REG_LEVEL_LOW   = 2'd0;
	localparam logic [1:0] REG_LEVEL_HIGH  = 2'd1;
	localparam logic [1:0] REG_SENSOR_KIND = 2'd2;

	localparam logic [6:0] LEVEL_LOW_RST  = 7'd88;
	localparam logic [6:0] LEVEL_HIGH_RST = 7'd89;

	localparam logic [13:0]      REED_MUL     = 14'd9738;
	localparam logic [5:0]       TAPE_MUL     = 6'd50;
	localparam logic [LVL_W-1:0] TAPE_FULL    = 16'd25600;
	localparam logic [LVL_W-1:0] OVERFULL_Q88 = 16'd24320;
	localparam logic [LVL_W-1:0] LVL_MAX      = 16'd38913;

	typedef struct packed {
		logic [1:0] op;
		logic [9:0] sample;
		logic       switch_on;
	} lahf_in_t;

	typedef struct packed {
		logic             valve_on;
		logic             auto_mode;
		logic [LVL_W-1:0] level_avg;
		logic             avg_valid;
	} lahf_out_t;

	typedef struct packed {
		logic [1:0] op;
		logic       switch_on;
		logic       full;
	} lahf_cmd_t;

endpackage

// ===== sv/lahf_conv.sv =====
// Converter reading to fill percent in Q8.8 for both sensor kinds.
module lahf_conv import lahf_pkg::*; (
	input  logic [9:0]       sample,
	input  logic             sensor_kind,
	output logic [LVL_W-1:0] lvl
);

	logic [23:0]      reed_prod;
	logic [LVL_W-1:0] tape_prod;

	always_comb begin
		reed_prod = {14'd0, sample} * {10'd0, REED_MUL};
		tape_prod = {6'd0, sample} * {10'd0, TAPE_MUL};
		if (!sensor_kind) begin
			lvl = reed_prod[23:8];
		end else if (tape_prod >= TAPE_FULL) begin
			lvl = '0;
		end else begin
			lvl = TAPE_FULL - tape_prod;
		end
	end

endmodule

// ===== sv/lahf_ring.sv =====
// Sample ring memory with write position, fill flag and running sum.
module lahf_ring import lahf_pkg::*; #(
	parameter int AVG_DEPTH = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                step,
	input  logic [LVL_W-1:0]                    lvl,
	output logic [LVL_W+$clog2(AVG_DEPTH)-1:0] sum_nx,
	output logic                                full_nx
);

	localparam int unsigned POS_W = $clog2(AVG_DEPTH);
	localparam int unsigned SUM_W = LVL_W + POS_W;
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(AVG_DEPTH - 1);

	logic [LVL_W-1:0] ring_mem_q [AVG_DEPTH];
	logic [LVL_W-1:0] old_q;
	logic [POS_W-1:0] pos_q;
	logic             full_q;
	logic [SUM_W-1:0] sum_q;

	logic [POS_W-1:0] pos_nx;
	logic [POS_W-1:0] rd_addr;
	logic [LVL_W-1:0] old_val;
	logic             last;

	// The entry under the write position is prefetched, so the oldest
	// sample is at hand when the next one arrives.
	always_comb begin
		last    = (pos_q == POS_LAST);
		pos_nx  = last ? '0 : pos_q + POS_W'(1);
		rd_addr = step ? pos_nx : pos_q;
		old_val = full_q ? old_q : '0;
		sum_nx  = step ? (sum_q - SUM_W'(old_val) + SUM_W'(lvl)) : sum_q;
		full_nx = full_q | (step & last);
	end

	always_ff @(posedge clk) begin
		if (step) begin
			ring_mem_q[pos_q] <= lvl;
		end
		old_q <= ring_mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			full_q <= 1'b0;
			sum_q  <= '0;
		end else if (step) begin
			pos_q  <= pos_nx;
			full_q <= full_nx;
			sum_q  <= sum_nx;
		end
	end

endmodule

// ===== sv/lahf_ctrl.sv =====
// Average from the running sum and the valve and auto mode state machine.
module lahf_ctrl import lahf_pkg::*; #(
	parameter int AVG_DEPTH = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  lahf_cmd_t                           cmd,
	input  logic [LVL_W+$clog2(AVG_DEPTH)-1:0] sum,
	input  logic [6:0]                          level_low,
	input  logic [6:0]                          level_high,
	output lahf_out_t                           res
);

	localparam int unsigned POS_W  = $clog2(AVG_DEPTH);
	localparam int unsigned SUM_W  = LVL_W + POS_W;
	localparam int unsigned MUL_W  = SUM_W + 2;
	localparam int unsigned PROD_W = SUM_W + MUL_W;
	localparam int unsigned DIV_SH = SUM_W + POS_W;
	localparam logic [MUL_W-1:0] DIV_MUL = MUL_W'(((64'd1 << DIV_SH) +
		64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));

	logic             valve_q;
	logic             auto_q;
	logic             valve_nx;
	logic             auto_nx;
	logic [PROD_W-1:0] prod;
	logic [LVL_W-1:0] avg;
	logic [LVL_W-1:0] low_q88;
	logic [LVL_W-1:0] high_q88;

	// The sum is divided by the ring depth through a reciprocal multiply
	// that is exact over the whole range of the sum.
	always_comb begin
		prod     = {{MUL_W{1'b0}}, sum} * {{SUM_W{1'b0}}, DIV_MUL};
		avg      = cmd.full ? prod[DIV_SH +: LVL_W] : '0;
		low_q88  = LVL_W'({level_low, 8'h00});
		high_q88 = LVL_W'({level_high, 8'h00});
		valve_nx = valve_q;
		auto_nx  = auto_q;
		unique case (cmd.op)
			OP_SAMPLE: begin
				if (cmd.full) begin
					if (avg > OVERFULL_Q88 && auto_nx) begin
						auto_nx  = 1'b0;
						valve_nx = 1'b0;
					end
					if (auto_nx) begin
						if (avg < low_q88 && !valve_nx) begin
							valve_nx = 1'b1;
						end else if (avg > high_q88 && valve_nx) begin
							valve_nx = 1'b0;
						end
					end
				end
			end
			OP_VALVE: begin
				valve_nx = cmd.switch_on;
			end
			OP_AUTO: begin
				auto_nx = cmd.switch_on;
			end
			default: begin
			end
		endcase
		res.valve_on  = valve_nx;
		res.auto_mode = auto_nx;
		res.level_avg = avg;
		res.avg_valid = cmd.full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valve_q <= 1'b0;
			auto_q  <= 1'b1;
		end else if (en) begin
			valve_q <= valve_nx;
			auto_q  <= auto_nx;
		end
	end

endmodule

// ===== sv/level_average_hysteresis_fill.sv =====
// Top level of the level averaging fill valve controller.
//
// Each request on the input channel is a level sample or a valve or mode
// command; each one yields exactly one result request on the output channel,
// in order. A request is taken at a clock edge with in_valid high and
// in_stall low, and a result is taken with out_valid high and out_stall low.
// A request passes the ring stage, the control stage and the output register
// before its result shows on out_valid. One request can be accepted every
// cycle unless the receiver stalls: the running sum update in the ring stage
// and the valve and mode update in the control stage are each combinational.
// When the receiver stalls, the result is held in the output register and
// the two stages in front of it keep filling; in_stall rises only once all
// three stages hold requests.
// Reset clears the ring fill flag, the sum and the write position, selects
// auto mode with the valve closed and loads the register defaults. Register
// writes on the cfg port take effect at once and are meant for idle times.
module level_average_hysteresis_fill import lahf_pkg::*; #(
	parameter int AVG_DEPTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  logic             in_valid,
	output logic             in_stall,
	input  lahf_in_t         in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output lahf_out_t        out_data
);

	localparam int unsigned SUM_W = LVL_W + $clog2(AVG_DEPTH);

	logic [6:0]       level_low_q;
	logic [6:0]       level_high_q;
	logic             sensor_kind_q;

	lahf_in_t         in_s1;
	logic             v_s1;
	lahf_cmd_t        cmd_s2;
	logic [SUM_W-1:0] sum_s2;
	logic             v_s2;
	lahf_out_t        out_q;
	logic             out_valid_q;

	logic             rdy_o;
	logic             rdy2;
	logic             rdy1;
	logic             move1;
	logic             move2;
	logic             ring_step;
	logic [LVL_W-1:0] lvl;
	logic [SUM_W-1:0] sum_nx;
	logic             full_nx;
	lahf_out_t        res;

	always_comb begin
		rdy_o     = !out_valid_q || !out_stall;
		rdy2      = !v_s2 || rdy_o;
		rdy1      = !v_s1 || rdy2;
		move1     = v_s1 && rdy2;
		move2     = v_s2 && rdy_o;
		ring_step = move1 && (in_s1.op == OP_SAMPLE);
	end

	assign in_stall  = !rdy1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_low_q   <= LEVEL_LOW_RST;
			level_high_q  <= LEVEL_HIGH_RST;
			sensor_kind_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LEVEL_LOW:   level_low_q   <= cfg_wdata;
				REG_LEVEL_HIGH:  level_high_q  <= cfg_wdata;
				REG_SENSOR_KIND: sensor_kind_q <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	lahf_conv u_conv (
		.sample      (in_s1.sample),
		.sensor_kind (sensor_kind_q),
		.lvl         (lvl)
	);

	lahf_ring #(
		.AVG_DEPTH (AVG_DEPTH)
	) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (ring_step),
		.lvl     (lvl),
		.sum_nx  (sum_nx),
		.full_nx (full_nx)
	);

	lahf_ctrl #(
		.AVG_DEPTH (AVG_DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (move2),
		.cmd        (cmd_s2),
		.sum        (sum_s2),
		.level_low  (level_low_q),
		.level_high (level_high_q),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= in_valid;
			end
			if (rdy2) begin
				v_s2 <= move1;
			end
			if (rdy_o) begin
				out_valid_q <= move2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			in_s1 <= in_data;
		end
		if (move1) begin
			cmd_s2.op        <= in_s1.op;
			cmd_s2.switch_on <= in_s1.switch_on;
			cmd_s2.full      <= full_nx;
			sum_s2           <= sum_nx;
		end
		if (move2) begin
			out_q <= res;
		end
	end

	a_avg_zero_until_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.avg_valid |-> out_data.level_avg == '0)
		else $error("level_avg is not zero before the ring is full");

	a_avg_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.level_avg <= LVL_MAX)
		else $error("level_avg exceeds the largest sample value");

	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !rdy_o |=> v_s2 && $stable(sum_s2) && $stable(cmd_s2))
		else $error("control stage changed while blocked");

	a_full_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		move2 && cmd_s2.full |=> !v_s2 || cmd_s2.full)
		else $error("ring fill flag fell between requests");

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the level averaging fill valve controller.
`timescale 1ns / 1ps

module tb import lahf_pkg::*; ();

	localparam int DEPTH = 8;
	localparam int HOLD_CYCLES = 150;
	localparam int QUIET_LIMIT = 2000;
	localparam int MAX_REPORTS = 40;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [CFG_W-1:0] cfg_wdata;
	logic in_valid;
	logic in_stall;
	lahf_in_t in_data;
	logic out_valid;
	logic out_stall;
	lahf_out_t out_data;

	level_average_hysteresis_fill #(
		.AVG_DEPTH(DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	logic [15:0] fill_hist [DEPTH];
	int fill_pos;
	logic hist_full;
	logic [18:0] fill_sum;
	logic auto_on;
	logic valve_open;
	logic [6:0] thr_low;
	logic [6:0] thr_high;
	logic tape_sensor;

	lahf_out_t pending_status [$];
	lahf_out_t want;

	int errors;
	int requests_sent;
	int samples_sent;
	int results_seen;
	int overfull_trips;
	int reg_writes;
	int quiet_cycles;

	bit rand_stall;
	bit hold_req;
	int hold_cnt;
	int seg_left;
	bit seg_stall;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [15:0] fill_q88(logic [9:0] raw);
		logic [23:0] reed;
		logic [15:0] tape;
		reed = 24'(raw) * 24'(REED_MUL);
		tape = 16'(raw) * 16'(TAPE_MUL);
		if (!tape_sensor)
			return reed[23:8];
		if (tape >= TAPE_FULL)
			return '0;
		return TAPE_FULL - tape;
	endfunction

	function automatic lahf_out_t next_valve_status(lahf_in_t req);
		logic [15:0] lvl;
		logic [15:0] avg;
		lahf_out_t res;
		case (req.op)
			OP_SAMPLE: begin
				lvl = fill_q88(req.sample);
				fill_sum = fill_sum - 19'(fill_hist[fill_pos]) + 19'(lvl);
				fill_hist[fill_pos] = lvl;
				if (fill_pos == DEPTH - 1) begin
					fill_pos = 0;
					hist_full = 1'b1;
				end else begin
					fill_pos++;
				end
				if (hist_full) begin
					avg = 16'(fill_sum / DEPTH);
					if (avg > OVERFULL_Q88 && auto_on) begin
						auto_on = 1'b0;
						valve_open = 1'b0;
						overfull_trips++;
					end
					if (auto_on) begin
						if (avg < {1'b0, thr_low, 8'h00} && !valve_open)
							valve_open = 1'b1;
						else if (avg > {1'b0, thr_high, 8'h00} && valve_open)
							valve_open = 1'b0;
					end
				end
			end
			OP_VALVE: valve_open = req.switch_on;
			OP_AUTO: auto_on = req.switch_on;
			default: ;
		endcase
		res.valve_on = valve_open;
		res.auto_mode = auto_on;
		res.level_avg = hist_full ? 16'(fill_sum / DEPTH) : 16'd0;
		res.avg_valid = hist_full;
		return res;
	endfunction

	task automatic send_request(input lahf_in_t req);
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (in_stall);
		pending_status.push_back(next_valve_status(req));
		requests_sent++;
		if (req.op == OP_SAMPLE)
			samples_sent++;
	endtask

	task automatic sender_gap(input int cycles);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic wait_drain();
		sender_gap(1);
		while (pending_status.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_LEVEL_LOW: thr_low = val;
			REG_LEVEL_HIGH: thr_high = val;
			REG_SENSOR_KIND: tape_sensor = val[0];
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(input int low, input int high, input bit tape);
		wait_drain();
		write_reg(REG_LEVEL_LOW, 7'(low));
		write_reg(REG_LEVEL_HIGH, 7'(high));
		write_reg(REG_SENSOR_KIND, 7'(tape));
	endtask

	task automatic send_op(input logic [1:0] op, input int raw, input bit sw);
		lahf_in_t req;
		req.op = op;
		req.sample = 10'(raw);
		req.switch_on = sw;
		send_request(req);
	endtask

	function automatic logic [9:0] pick_sample();
		int pct;
		int center;
		int s;
		if ($urandom_range(0, 2) == 0)
			return 10'($urandom_range(0, 1023));
		case ($urandom_range(0, 4))
			0, 1: pct = thr_low;
			2, 3: pct = thr_high;
			default: pct = 95;
		endcase
		center = tape_sensor ? (25600 - pct * 256) / 50 : pct * 65536 / 9738;
		s = center + $urandom_range(0, 80) - 40;
		if (s < 0)
			s = 0;
		if (s > 1023)
			s = 1023;
		return 10'(s);
	endfunction

	function automatic lahf_in_t pick_request();
		lahf_in_t req;
		int r;
		r = $urandom_range(0, 99);
		req.sample = 10'($urandom_range(0, 1023));
		req.switch_on = 1'($urandom_range(0, 1));
		if (r < 72) begin
			req.op = OP_SAMPLE;
			req.sample = pick_sample();
		end else if (r < 84) begin
			req.op = OP_VALVE;
		end else if (r < 96) begin
			req.op = OP_AUTO;
		end else begin
			req.op = OP_UNUSED;
		end
		return req;
	endfunction

	task automatic random_burst(input int count, input bit idle);
		rand_stall = idle;
		repeat (count) begin
			if (idle && $urandom_range(0, 5) == 0)
				sender_gap($urandom_range(1, 16));
			send_request(pick_request());
		end
	endtask

	task automatic test_commands_unfilled();
		send_op(OP_VALVE, 0, 1'b1);
		send_op(OP_VALVE, 1023, 1'b0);
		send_op(OP_AUTO, 0, 1'b0);
		send_op(OP_AUTO, 1023, 1'b1);
		send_op(OP_UNUSED, 1023, 1'b1);
		send_op(OP_UNUSED, 0, 1'b0);
	endtask

	task automatic test_reed_fill_overfull();
		send_op(OP_SAMPLE, 0, 1'b0);
		send_op(OP_SAMPLE, 1023, 1'b1);
		send_op(OP_SAMPLE, 1, 1'b0);
		send_op(OP_SAMPLE, 1022, 1'b0);
		send_op(OP_SAMPLE, 512, 1'b0);
		send_op(OP_SAMPLE, 256, 1'b0);
		send_op(OP_SAMPLE, 768, 1'b0);
		send_op(OP_SAMPLE, 1023, 1'b0);
		send_op(OP_AUTO, 0, 1'b1);
		send_op(OP_UNUSED, 512, 1'b1);
	endtask

	task automatic test_tape_thresholds();
		configure(127, 0, 1'b1);
		send_op(OP_SAMPLE, 0, 1'b0);
		send_op(OP_SAMPLE, 511, 1'b0);
		send_op(OP_SAMPLE, 512, 1'b0);
		send_op(OP_SAMPLE, 1023, 1'b0);
		send_op(OP_SAMPLE, 1, 1'b0);
		configure(100, 100, 1'b1);
		send_op(OP_SAMPLE, 0, 1'b0);
		send_op(OP_AUTO, 0, 1'b1);
		send_op(OP_SAMPLE, 0, 1'b0);
	endtask

	task automatic test_backpressure();
		wait_drain();
		rand_stall = 1'b0;
		hold_req = 1'b1;
		repeat (24)
			send_request(pick_request());
		wait_drain();
	endtask

	task automatic test_random_levels();
		configure(88, 89, 1'b0);
		random_burst(180, 1'b1);
		configure(0, 0, 1'b1);
		random_burst(130, 1'b1);
		configure(100, 100, 1'b0);
		random_burst(130, 1'b1);
		configure(127, 127, 1'b1);
		random_burst(100, 1'b1);
		configure(90, 20, 1'b0);
		random_burst(100, 1'b1);
		configure(30, 70, 1'b1);
		random_burst(170, 1'b1);
		configure($urandom_range(40, 94), $urandom_range(40, 100), 1'b0);
		random_burst(170, 1'b1);
	endtask

	task automatic test_full_rate();
		configure($urandom_range(0, 100), $urandom_range(0, 100),
			1'($urandom_range(0, 1)));
		random_burst(200, 1'b0);
	endtask

	always @(negedge clk) begin
		if (hold_req) begin
			out_stall <= 1'b1;
			hold_cnt++;
			if (hold_cnt == HOLD_CYCLES) begin
				hold_req = 1'b0;
				hold_cnt = 0;
			end
		end else if (!rand_stall) begin
			out_stall <= 1'b0;
		end else begin
			if (seg_left == 0) begin
				seg_stall = ~seg_stall;
				seg_left = seg_stall ? $urandom_range(1, 16) : $urandom_range(1, 24);
			end
			seg_left--;
			out_stall <= seg_stall;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_status.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected result %p", $time, out_data);
			end else begin
				want = pending_status.pop_front();
				if (out_data.valve_on !== want.valve_on) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: valve_on expected %0d actual %0d", $time,
							want.valve_on, out_data.valve_on);
				end
				if (out_data.auto_mode !== want.auto_mode) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: auto_mode expected %0d actual %0d", $time,
							want.auto_mode, out_data.auto_mode);
				end
				if (out_data.level_avg !== want.level_avg) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: level_avg expected %0d actual %0d", $time,
							want.level_avg, out_data.level_avg);
				end
				if (out_data.avg_valid !== want.avg_valid) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: avg_valid expected %0d actual %0d", $time,
							want.avg_valid, out_data.avg_valid);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("%0t: no request moved for %0d cycles", $time, QUIET_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_LEVEL_LOW;
		cfg_wdata = '0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		foreach (fill_hist[i])
			fill_hist[i] = '0;
		fill_pos = 0;
		hist_full = 1'b0;
		fill_sum = '0;
		auto_on = 1'b1;
		valve_open = 1'b0;
		thr_low = LEVEL_LOW_RST;
		thr_high = LEVEL_HIGH_RST;
		tape_sensor = 1'b0;
		errors = 0;
		requests_sent = 0;
		samples_sent = 0;
		results_seen = 0;
		overfull_trips = 0;
		reg_writes = 0;
		quiet_cycles = 0;
		rand_stall = 1'b0;
		hold_req = 1'b0;
		hold_cnt = 0;
		seg_left = 0;
		seg_stall = 1'b1;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_commands_unfilled();
		test_reed_fill_overfull();
		test_tape_thresholds();
		test_backpressure();
		test_random_levels();
		test_full_rate();

		wait_drain();
		repeat (8) @(posedge clk);
		$display("Covered %0d requests (%0d samples) and %0d results",
			requests_sent, samples_sent, results_seen);
		$display("over %0d register writes, %0d overfull trips and one long output hold-off.",
			reg_writes, overfull_trips);
		if (errors == 0 && pending_status.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
